// File: hw/rtl/scc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants for the calendar real-time clock.
// Holds the command codes, the calendar constants and the controller to
// datapath command and status structs.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int unsigned CountW = 32;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET_CAL = 2'd1,
        CMD_SET_RAW = 2'd2,
        CMD_READ = 2'd3
    } cmd_t;

    localparam logic [11:0] EpochYear = 12'd1970;
    localparam logic [11:0] LastSetYear = 12'd2099;
    localparam logic [31:0] SecPerDay = 32'd86400;
    localparam logic [31:0] SecPerHour = 32'd3600;
    localparam logic [31:0] SecPerMin = 32'd60;
    localparam logic [31:0] SecPerYear = 32'd31536000;
    localparam logic [31:0] SecPerLeapYear = 32'd31622400;

    // Datapath operation selected by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_INIT,
        OP_SET_YEAR,
        OP_SET_MONTH,
        OP_SET_FINISH,
        OP_DAY_STEP,
        OP_REM_STEP,
        OP_MIN_STEP,
        OP_HOUR_STEP,
        OP_SEC_STEP,
        OP_YEAR_STEP,
        OP_MONTH_STEP
    } op_t;

    typedef struct packed {
        op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        logic year_bad;
        logic set_year_done;
        logic set_month_done;
        logic year_done;
        logic month_done;
    } dp_status_t;

    // Leap test for years in 1970..2106.
    function automatic logic is_leap(input logic [11:0] y);
        logic lp;
        lp = (y[1:0] == 2'b00) && (y != 12'd2100);
        return lp;
    endfunction

    // Days in zero-based month m0 of year y.
    function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m0);
        logic [4:0] d;
        case (m0)
            4'd1: d = is_leap(y) ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage : scc_pkg
`default_nettype wire

// File: hw/rtl/scc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_datapath: count register and calendar arithmetic.
// Builds the count from a calendar set one year and one month a cycle. The
// decode splits days, hours, minutes and the weekday with constant
// reciprocal multiplies in the day, remainder, minute, hour and second steps, then walks years and months.
// ----------------------------------------------------------------------------
module scc_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire scc_pkg::ctl_cmd_t     ctl,
    input  wire logic [1:0]            cmd,
    input  wire logic [11:0]           set_year,
    input  wire logic [3:0]            set_month,
    input  wire logic [4:0]            set_day,
    input  wire logic [4:0]            set_hour,
    input  wire logic [5:0]            set_minute,
    input  wire logic [5:0]            set_second,
    input  wire logic [31:0]           set_count,
    output scc_pkg::dp_status_t        sts,
    output logic                       status,
    output logic [31:0]                seconds_count,
    output logic [11:0]                cal_year,
    output logic [3:0]                 cal_month,
    output logic [4:0]                 cal_day,
    output logic [4:0]                 cal_hour,
    output logic [5:0]                 cal_minute,
    output logic [5:0]                 cal_second,
    output logic [2:0]                 weekday
);
    import scc_pkg::*;

    // Reciprocals, exact over the operand ranges used below:
    // count/128 by 675 (2^35), seconds/4 by 15 (2^19),
    // minutes/4 by 15 (2^13) and days by 7 (2^19).
    localparam logic [25:0] DayRecip = 26'd50903317;
    localparam logic [15:0] MinRecip = 16'd34953;
    localparam logic [9:0]  HourRecip = 10'd547;
    localparam logic [16:0] WeekRecip = 17'd74899;

    logic [31:0] count_reg, count_next;
    logic [31:0] acc_reg, acc_next;
    logic [11:0] yr_reg, yr_next;
    logic [3:0]  mo_reg, mo_next;
    logic [11:0] sy_reg;
    logic [3:0]  smo_reg;
    logic [4:0]  sd_reg, sh_reg;
    logic [5:0]  smi_reg, ss_reg;
    logic [1:0]  cmd_reg;
    logic        status_reg, status_next;
    logic [16:0] days_reg, days_next;
    logic [16:0] dwk_reg, dwk_next;
    logic [16:0] rem_reg, rem_next;
    logic [4:0]  hr_reg, hr_next;
    logic [5:0]  mi_reg, mi_next;
    logic [10:0] tmin_reg, tmin_next;
    logic [12:0] wq_reg, wq_next;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [3:0]  smon;
    logic [50:0] day_prod;
    logic [24:0] day_left;
    logic [29:0] min_prod;
    logic [17:0] hr_prod;
    logic [31:0] wk_prod;
    logic [10:0] min_left;

    // Clamp the set month into 1..12.
    always_comb
    begin
        if (sy_reg == 12'd0 && smo_reg == 4'd0)
            smon = 4'd1;
        else if (smo_reg == 4'd0)
            smon = 4'd1;
        else if (smo_reg > 4'd12)
            smon = 4'd12;
        else
            smon = smo_reg;
    end

    assign ylen = is_leap(yr_reg) ? 9'd366 : 9'd365;
    assign mlen = month_days(yr_reg, mo_reg);

    // Quotient and remainder terms for the decode steps.
    assign day_prod = {25'd0, acc_reg[31:7]} * {25'd0, DayRecip};
    assign day_left = acc_reg[31:7] - {8'd0, days_reg} * 25'd675;
    assign min_prod = {15'd0, rem_reg[16:2]} * {14'd0, MinRecip};
    assign hr_prod = {9'd0, tmin_reg[10:2]} * {8'd0, HourRecip};
    assign wk_prod = {15'd0, dwk_reg} * {15'd0, WeekRecip};
    assign min_left = tmin_reg - {6'd0, hr_reg} * 11'd60;

    // Status flags for the controller.
    always_comb
    begin
        sts.year_bad = (sy_reg < EpochYear) || (sy_reg > LastSetYear);
        sts.set_year_done = (yr_reg >= sy_reg);
        sts.set_month_done = (mo_reg + 4'd1 >= smon);
        sts.year_done = (days_reg < {8'd0, ylen});
        sts.month_done = (mo_reg >= 4'd11) || (days_reg < {12'd0, mlen});
    end

    // One datapath operation per cycle as the controller selects.
    always_comb
    begin
        count_next = count_reg;
        acc_next = acc_reg;
        yr_next = yr_reg;
        mo_next = mo_reg;
        status_next = status_reg;
        days_next = days_reg;
        dwk_next = dwk_reg;
        rem_next = rem_reg;
        hr_next = hr_reg;
        mi_next = mi_reg;
        tmin_next = tmin_reg;
        wq_next = wq_reg;
        case (ctl.op)
            OP_LOAD:
            begin
                status_next = 1'b0;
                case (cmd_t'(cmd_reg))
                    CMD_TICK: count_next = count_reg + 32'd1;
                    CMD_SET_RAW: count_next = set_count;
                    default: count_next = count_reg;
                endcase
                if (cmd_t'(cmd_reg) == CMD_SET_CAL)
                    status_next = sts.year_bad;
            end
            OP_SET_INIT:
            begin
                acc_next = 32'd0;
                yr_next = EpochYear;
                mo_next = 4'd0;
            end
            OP_SET_YEAR:
            begin
                if (!sts.set_year_done)
                begin
                    acc_next = acc_reg + (is_leap(yr_reg) ? SecPerLeapYear : SecPerYear);
                    yr_next = yr_reg + 12'd1;
                end
            end
            OP_SET_MONTH:
            begin
                if (!sts.set_month_done)
                begin
                    acc_next = acc_reg + {15'd0, mlen} * SecPerDay;
                    mo_next = mo_reg + 4'd1;
                end
            end
            OP_SET_FINISH:
            begin
                count_next = acc_reg + ({27'd0, sd_reg} - 32'd1) * SecPerDay
                             + {27'd0, sh_reg} * SecPerHour
                             + {26'd0, smi_reg} * SecPerMin + {26'd0, ss_reg};
                acc_next = count_next;
                days_next = 17'd0;
            end
            OP_DAY_STEP:
            begin
                // Whole days since the epoch.
                days_next = {1'b0, day_prod[50:35]};
            end
            OP_REM_STEP:
            begin
                // Seconds into the day, and the day count offset for Thursday.
                rem_next = {day_left[9:0], acc_reg[6:0]};
                dwk_next = days_reg + 17'd4;
            end
            OP_MIN_STEP:
            begin
                tmin_next = min_prod[29:19];
                wq_next = wk_prod[31:19];
            end
            OP_HOUR_STEP:
            begin
                hr_next = hr_prod[17:13];
                rem_next = rem_reg - {6'd0, tmin_reg} * 17'd60;
                dwk_next = dwk_reg - {4'd0, wq_reg} * 17'd7;
            end
            OP_SEC_STEP:
            begin
                mi_next = min_left[5:0];
            end
            OP_YEAR_STEP:
            begin
                if (!sts.year_done)
                begin
                    days_next = days_reg - {8'd0, ylen};
                    yr_next = yr_reg + 12'd1;
                end
            end
            OP_MONTH_STEP:
            begin
                if (!sts.month_done)
                begin
                    days_next = days_reg - {12'd0, mlen};
                    mo_next = mo_reg + 4'd1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Count and status registers with reset; working registers without.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 32'd0;
            status_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_NONE)
        begin
            cmd_reg <= cmd;
            sy_reg <= set_year;
            smo_reg <= set_month;
            sd_reg <= set_day;
            sh_reg <= set_hour;
            smi_reg <= set_minute;
            ss_reg <= set_second;
        end
        // Seed the decode from the final count.
        if (ctl.op == OP_SET_FINISH || ctl.op == OP_LOAD)
        begin
            acc_reg <= (ctl.op == OP_LOAD) ? count_next : acc_next;
            days_reg <= 17'd0;
            rem_reg <= count_next[16:0];
            hr_reg <= 5'd0;
            mi_reg <= 6'd0;
            yr_reg <= EpochYear;
            mo_reg <= 4'd0;
            dwk_reg <= 17'd4;
        end
        else
        begin
            acc_reg <= acc_next;
            days_reg <= days_next;
            rem_reg <= rem_next;
            hr_reg <= hr_next;
            mi_reg <= mi_next;
            yr_reg <= yr_next;
            mo_reg <= mo_next;
            dwk_reg <= dwk_next;
            tmin_reg <= tmin_next;
            wq_reg <= wq_next;
        end
    end

    assign status = status_reg;
    assign seconds_count = count_reg;
    assign cal_year = yr_reg;
    assign cal_month = mo_reg + 4'd1;
    assign cal_day = days_reg[4:0] + 5'd1;
    assign cal_hour = hr_reg;
    assign cal_minute = mi_reg;
    assign cal_second = rem_reg[5:0];
    assign weekday = dwk_reg[2:0];

endmodule : scc_datapath
`default_nettype wire

// File: hw/rtl/scc_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_control: sequencer for one command.
// Steps the datapath through load, calendar set (valid set commands only), day split, time and
// weekday split, year walk and month walk, then strobes the result.
// ----------------------------------------------------------------------------
module scc_control (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          cmd,
    input  wire scc_pkg::dp_status_t sts,
    output scc_pkg::ctl_cmd_t        ctl,
    output logic                     busy,
    output logic                     done
);
    import scc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_SINIT, S_SYEAR, S_SMONTH, S_SFIN,
        S_DAY, S_REM, S_MIN, S_HOUR, S_SEC, S_YEAR, S_MONTH, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;
    logic   is_cal_reg, is_cal_next;

    // Command to the datapath follows the state.
    always_comb
    begin
        case (state_reg)
            S_LOAD: ctl.op = OP_LOAD;
            S_SINIT: ctl.op = OP_SET_INIT;
            S_SYEAR: ctl.op = OP_SET_YEAR;
            S_SMONTH: ctl.op = OP_SET_MONTH;
            S_SFIN: ctl.op = OP_SET_FINISH;
            S_DAY: ctl.op = OP_DAY_STEP;
            S_REM: ctl.op = OP_REM_STEP;
            S_MIN: ctl.op = OP_MIN_STEP;
            S_HOUR: ctl.op = OP_HOUR_STEP;
            S_SEC: ctl.op = OP_SEC_STEP;
            S_YEAR: ctl.op = OP_YEAR_STEP;
            S_MONTH: ctl.op = OP_MONTH_STEP;
            default: ctl.op = OP_NONE;
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        is_cal_next = is_cal_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOAD;
                    busy_next = 1'b1;
                    is_cal_next = (cmd_t'(cmd) == CMD_SET_CAL);
                end
            end
            S_LOAD:
            begin
                if (is_cal_reg && !sts.year_bad)
                    state_next = S_SINIT;
                else
                    state_next = S_DAY;
            end
            S_SINIT: state_next = S_SYEAR;
            S_SYEAR:
            begin
                if (sts.set_year_done)
                    state_next = S_SMONTH;
            end
            S_SMONTH:
            begin
                if (sts.set_month_done)
                    state_next = S_SFIN;
            end
            S_SFIN: state_next = S_DAY;
            S_DAY: state_next = S_REM;
            S_REM: state_next = S_MIN;
            S_MIN: state_next = S_HOUR;
            S_HOUR: state_next = S_SEC;
            S_SEC: state_next = S_YEAR;
            S_YEAR:
            begin
                if (sts.year_done)
                    state_next = S_MONTH;
            end
            S_MONTH:
            begin
                if (sts.month_done)
                begin
                    state_next = S_DONE;
                    done_next = 1'b1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
                busy_next = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            is_cal_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            is_cal_reg <= is_cal_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule : scc_control
`default_nettype wire

// File: hw/rtl/seconds_counter_calendar_rtc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seconds_counter_calendar_rtc: calendar real-time clock top level.
// A 32-bit seconds count since 1970 with tick, calendar set, raw set and read
// commands, each returning the decoded date, time and weekday.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays
// high until the result has been shown. The result appears for one cycle
// with done high and cannot be held off. The time from the transfer to done
// depends on the data: for a tick, raw set, read or refused calendar set it
// grows with the years past 1970 and the months before the decoded month,
// and a valid calendar set adds its own walks over the years and months it
// sets. Days, hours, minutes and the weekday are split off in five fixed
// steps; only the year and month walks go one step a cycle. Busy drops in
// the cycle after done.
module seconds_counter_calendar_rtc (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    input  wire logic [1:0]  cmd,
    input  wire logic [11:0] set_year,
    input  wire logic [3:0]  set_month,
    input  wire logic [4:0]  set_day,
    input  wire logic [4:0]  set_hour,
    input  wire logic [5:0]  set_minute,
    input  wire logic [5:0]  set_second,
    input  wire logic [31:0] set_count,
    output logic             status,
    output logic [31:0]      seconds_count,
    output logic [11:0]      cal_year,
    output logic [3:0]       cal_month,
    output logic [4:0]       cal_day,
    output logic [4:0]       cal_hour,
    output logic [5:0]       cal_minute,
    output logic [5:0]       cal_second,
    output logic [2:0]       weekday
);
    import scc_pkg::*;

    ctl_cmd_t   ctl;
    dp_status_t sts;

    scc_control u_ctl (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .sts(sts),
        .ctl(ctl), .busy(busy), .done(done)
    );

    scc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .cmd(cmd),
        .set_year(set_year), .set_month(set_month), .set_day(set_day),
        .set_hour(set_hour), .set_minute(set_minute), .set_second(set_second),
        .set_count(set_count), .sts(sts), .status(status),
        .seconds_count(seconds_count), .cal_year(cal_year),
        .cal_month(cal_month), .cal_day(cal_day), .cal_hour(cal_hour),
        .cal_minute(cal_minute), .cal_second(cal_second), .weekday(weekday)
    );

endmodule : seconds_counter_calendar_rtc
`default_nettype wire
